// File: src/ipv4dq_pkg.sv
// Package: shared types and character constants for the dotted-quad parser.
`timescale 1ns / 1ps

package ipv4dq_pkg;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_END  = 8'h00;

  localparam logic [9:0] OCTET_LIMIT = 10'd256;
  localparam logic [2:0] OCTET_COUNT = 3'd4;

  typedef struct packed {
    logic [1:0]  digit_count;
    logic [9:0]  octet_value;
    logic        lead_zero;
    logic [2:0]  octet_index;
    logic [31:0] gathered_octets;
    logic        error_seen;
  } state_t;

  typedef struct packed {
    logic        last;
    logic        ok;
    logic [31:0] addr;
  } result_t;

endpackage

// File: src/ipv4dq_step.sv
// Step logic: next parser state and the result for one character.
`timescale 1ns / 1ps

module ipv4dq_step (
  input  ipv4dq_pkg::state_t  state_i,
  input  logic [7:0]          char_i,
  output ipv4dq_pkg::state_t  state_o,
  output ipv4dq_pkg::result_t res_o
);

  logic [7:0]         diff;
  logic [3:0]         digit;
  logic [9:0]         value_nxt;
  logic               is_digit;
  logic               is_sep;
  ipv4dq_pkg::state_t upd;

  always_comb begin
    diff      = char_i - ipv4dq_pkg::CHAR_ZERO;
    digit     = diff[3:0];
    value_nxt = {state_i.octet_value[6:0], 3'b000} + {state_i.octet_value[8:0], 1'b0}
                + {6'd0, digit};
    is_digit  = (char_i >= ipv4dq_pkg::CHAR_ZERO) && (char_i <= ipv4dq_pkg::CHAR_NINE);
    is_sep    = (char_i == ipv4dq_pkg::CHAR_DOT) || (char_i == ipv4dq_pkg::CHAR_END);
    upd       = state_i;

    if (!state_i.error_seen) begin
      if (is_digit) begin
        if (state_i.digit_count == 2'd3) begin
          upd.error_seen = 1'b1;
        end else if (state_i.digit_count == 2'd1 && state_i.lead_zero) begin
          upd.error_seen = 1'b1;
        end else begin
          if (state_i.digit_count == 2'd0) begin
            upd.lead_zero = (digit == 4'd0);
          end
          upd.octet_value = value_nxt;
          upd.digit_count = state_i.digit_count + 2'd1;
        end
      end else if (is_sep) begin
        if (state_i.octet_index >= ipv4dq_pkg::OCTET_COUNT) begin
          upd.error_seen = 1'b1;
        end else if (state_i.digit_count == 2'd0) begin
          upd.error_seen = 1'b1;
        end else if (state_i.octet_value >= ipv4dq_pkg::OCTET_LIMIT) begin
          upd.error_seen = 1'b1;
        end else begin
          upd.gathered_octets = {state_i.gathered_octets[23:0], state_i.octet_value[7:0]};
          upd.octet_index     = state_i.octet_index + 3'd1;
          upd.digit_count     = 2'd0;
          upd.octet_value     = 10'd0;
          upd.lead_zero       = 1'b0;
        end
      end else begin
        upd.error_seen = 1'b1;
      end
    end

    res_o.last = (char_i == ipv4dq_pkg::CHAR_END);
    res_o.ok   = !upd.error_seen && (upd.octet_index == ipv4dq_pkg::OCTET_COUNT);
    res_o.addr = res_o.ok ? upd.gathered_octets : '0;
    state_o    = res_o.last ? '0 : upd;
  end

endmodule

// File: src/ipv4_dotted_quad_parser_core.sv
// Top level: dotted-quad text parser with input and result registers.
//
//   channel | dir | tdata          | tuser    | note
//   in_     | in  | [7:0] char     | -        | one character per transfer
//   out_    | out | [31:0] address | success  | one transfer per zero byte
//
// One character per cycle unless a zero byte waits on a stalled output.
// Characters pass the input register into the parser state; a zero byte also loads the result.
// rst_n is synchronous and active low; it clears the parser state and both valid flags.
// A stalled result holds only the zero-byte character behind it; other characters still advance.
`timescale 1ns / 1ps

module ipv4_dotted_quad_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] address
  output logic        out_tuser   // [0] success
);

  logic                in_valid_r;
  logic [7:0]          in_char_r;
  ipv4dq_pkg::state_t  state_r;
  ipv4dq_pkg::state_t  state_nxt;
  ipv4dq_pkg::result_t res;
  logic                out_valid_r;
  logic [31:0]         out_addr_r;
  logic                out_ok_r;
  logic                out_free;
  logic                advance;
  logic                load_res;

  ipv4dq_step u_step (
    .state_i (state_r),
    .char_i  (in_char_r),
    .state_o (state_nxt),
    .res_o   (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!res.last || out_free);
  assign load_res  = advance && res.last;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      out_addr_r <= res.addr;
      out_ok_r   <= res.ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_ok_r;

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> (out_addr_r == 32'd0))
    else $error("failed parse carries a nonzero address");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    load_res |=> (state_r == '0))
    else $error("parser state not cleared after end of string");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.octet_index <= ipv4dq_pkg::OCTET_COUNT)
    else $error("octet index beyond four");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.error_seen && !load_res) |=> state_r.error_seen)
    else $error("error flag dropped before end of string");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !load_res)
    else $error("result loaded over a stalled result");

endmodule
